FILE: rtl/irpd_pkg.sv
// Shared types, constants and the per-frame word update for the pulse-distance IR frame sender.
// No dependencies; every other file of the block refers to this one by scoped names.
package irpd_pkg;

  localparam int BYTE_W        = 8;
  localparam int CMD_W         = 16;
  localparam int CH_W          = 3;
  localparam int TICK_W        = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;
  localparam int REPEATS_DEF   = 6;
  localparam int WORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_GAP,
    PH_MARK,
    PH_SPACE
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL,
    CFG_MARK,
    CFG_ZERO_SPACE,
    CFG_ONE_SPACE,
    CFG_STARTSTOP_SPACE
  } cfg_reg_t;

  // Toggle bit 3 of the top nibble (unless only bit 2 may be set), then rebuild the checksum.
  function automatic logic [CMD_W-1:0] next_frame_word(input logic [CMD_W-1:0] w);
    logic [3:0] n1;
    logic [3:0] n2;
    logic [3:0] n3;
    logic [3:0] n4;
    n1 = w[15:12];
    n2 = w[11:8];
    n3 = w[7:4];
    if ((n1 & 4'hb) != 4'h0) n1 = n1 ^ 4'h8;
    n4 = 4'hf ^ n1 ^ n2 ^ n3;
    return {n1, n2, n3, n4};
  endfunction

endpackage

FILE: rtl/irpd_req_if.sv
// Request channel of the IR frame sender: valid/ready plus operation and command bytes.
// Depends on irpd_pkg for field widths.
interface irpd_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [irpd_pkg::BYTE_W-1:0]  command_high;
  logic [irpd_pkg::BYTE_W-1:0]  command_low;

  modport source (output valid, output operation, output command_high, output command_low,
                  input ready);
  modport sink   (input valid, input operation, input command_high, input command_low,
                  output ready);
endinterface

FILE: rtl/irpd_rsp_if.sv
// Result channel of the IR frame sender: valid/ready plus carrier enable, busy and word.
// Depends on irpd_pkg for field widths.
interface irpd_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ir_drive;
  logic                        busy_res;
  logic [irpd_pkg::CMD_W-1:0]  word_on_air;

  modport source (output valid, output ir_drive, output busy_res, output word_on_air,
                  input ready);
  modport sink   (input valid, input ir_drive, input busy_res, input word_on_air,
                  output ready);
endinterface

FILE: rtl/ir_pulse_distance_frame_sender.sv
// Pulse-distance IR frame sender, top level. Each result is valid the cycle after acceptance.
// Throughput: one item per clock; the request side stalls only while the result register is
// full and not taken. All phase skipping for zero-length gaps, marks and spaces resolves in
// the same cycle through a priority search over the WORD_BITS+2 symbols of a frame.
// Reset (rst, synchronous, active high): idle, word zero, configuration to its defaults.
module ir_pulse_distance_frame_sender #(
  parameter int REPEATS   = irpd_pkg::REPEATS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  irpd_req_if.sink                           req,
  irpd_rsp_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int WORD_BITS = irpd_pkg::WORD_BITS_DEF;
  localparam int IDX_N    = WORD_BITS + 2;        // start, data bits, stop
  localparam int IW       = $clog2(IDX_N);
  localparam int RW       = $clog2(REPEATS + 1);
  localparam int LAST     = WORD_BITS + 1;        // index of the stop symbol
  localparam int CW       = irpd_pkg::CMD_W;
  localparam int TW       = irpd_pkg::TICK_W;

  // Configuration registers
  logic [irpd_pkg::CH_W-1:0] channel;
  logic [TW-1:0]             mark_len;
  logic [TW-1:0]             zero_len;
  logic [TW-1:0]             one_len;
  logic [TW-1:0]             ss_len;

  // Sequencer state
  logic [CW-1:0]             word, word_next;
  logic [RW-1:0]             rep, rep_next;
  logic [IW-1:0]             idx, idx_next;
  irpd_pkg::phase_t          phase, phase_next;
  logic [TW-1:0]             cnt, cnt_next;
  logic                      sending, sending_next;

  // Result register
  logic                      rsp_valid;
  logic                      res_drive;
  logic                      res_busy;
  logic [CW-1:0]             res_word;

  logic                      accept;
  logic                      is_load;
  logic [CW-1:0]             load_word;
  logic [CW-1:0]             sel_word;
  logic [RW-1:0]             rep_inc;
  logic [TW-1:0]             gap_first;
  logic [TW-1:0]             gap_rep;
  logic [TW-1:0]             cur_len;
  logic [TW:0]               cnt_inc;
  logic [IDX_N-1:0]          bitv;
  logic [IDX_N-1:0]          nz;
  logic                      drive;
  logic                      expire;
  logic                      go_mark;
  logic                      go_space;
  logic                      go_end;
  logic [IW-1:0]             mark_j;
  logic                      found;
  logic [IW-1:0]             found_k;

  // Accept a new item whenever the result register is free or being drained.
  assign req.ready       = !rsp_valid || rsp.ready;
  assign accept          = req.valid && req.ready;
  assign rsp.valid       = rsp_valid;
  assign rsp.ir_drive    = res_drive;
  assign rsp.busy_res    = res_busy;
  assign rsp.word_on_air = res_word;

  assign is_load   = !req.operation;
  assign load_word = irpd_pkg::next_frame_word({req.command_high, req.command_low});
  // A load only takes effect when idle; the search then runs over the fresh word.
  assign sel_word  = (is_load && !sending) ? load_word : word;
  assign rep_inc   = (is_load ? RW'(0) : rep) + RW'(1);

  // Gap lengths: first frame 3*(4-channel), saturating; later frames 3*(5+2*channel).
  always_comb begin
    logic [2:0] p;
    logic [4:0] q;
    p = (channel <= 3'd4) ? 3'(3'd4 - channel) : 3'd0;
    q = 5'd5 + 5'({channel, 1'b0});
    gap_first = TW'({p, 1'b0}) + TW'(p);
    gap_rep   = TW'({q, 1'b0}) + TW'(q);
  end

  // Per-symbol data bit (MSB first) and whether its space has nonzero length.
  always_comb begin
    logic [CW-1:0] sh;
    for (int k = 0; k < IDX_N; k++) begin
      sh = sel_word >> (WORD_BITS - k);
      if (k == 0 || k > WORD_BITS) begin
        bitv[k] = 1'b0;
        nz[k]   = (ss_len != '0);
      end else begin
        bitv[k] = sh[0];
        nz[k]   = sh[0] ? (one_len != '0) : (zero_len != '0);
      end
    end
  end

  // Length of the phase in progress.
  always_comb begin
    case (phase)
      irpd_pkg::PH_GAP:   cur_len = (rep == '0) ? gap_first : gap_rep;
      irpd_pkg::PH_MARK:  cur_len = mark_len;
      irpd_pkg::PH_SPACE: begin
        if (idx == '0 || idx > IW'(WORD_BITS)) cur_len = ss_len;
        else                                   cur_len = bitv[idx] ? one_len : zero_len;
      end
      default:            cur_len = '0;
    endcase
  end

  // Decide where this item moves the sequencer before zero-length phases are skipped.
  always_comb begin
    go_mark  = 1'b0;
    go_space = 1'b0;
    go_end   = 1'b0;
    expire   = 1'b0;
    mark_j   = '0;
    cnt_inc  = {1'b0, cnt} + (TW+1)'(1);
    if (is_load) begin
      if (!sending && gap_first == '0) go_mark = 1'b1;
    end else if (sending && cnt_inc >= {1'b0, cur_len}) begin
      expire = 1'b1;
      case (phase)
        irpd_pkg::PH_GAP:  go_mark = 1'b1;
        irpd_pkg::PH_MARK: begin
          if (nz[idx])                  go_space = 1'b1;
          else if (idx == IW'(LAST))    go_end   = 1'b1;
          else begin
            go_mark = 1'b1;
            mark_j  = idx + IW'(1);
          end
        end
        irpd_pkg::PH_SPACE: begin
          if (idx < IW'(LAST)) begin
            go_mark = 1'b1;
            mark_j  = idx + IW'(1);
          end else begin
            go_end = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // With a zero mark, land on the first symbol at or after mark_j whose space is nonzero.
  always_comb begin
    found   = 1'b0;
    found_k = '0;
    for (int k = IDX_N - 1; k >= 0; k--) begin
      if (IW'(k) >= mark_j && nz[k]) begin
        found   = 1'b1;
        found_k = IW'(k);
      end
    end
  end

  // Next state and carrier enable for this item.
  always_comb begin
    word_next    = word;
    rep_next     = rep;
    idx_next     = idx;
    phase_next   = phase;
    cnt_next     = cnt;
    sending_next = sending;
    drive        = 1'b0;
    if (is_load) begin
      if (!sending) begin
        sending_next = 1'b1;
        rep_next     = '0;
        word_next    = load_word;
        idx_next     = '0;
        cnt_next     = '0;
        phase_next   = irpd_pkg::PH_GAP;
      end
    end else if (sending) begin
      drive    = (phase == irpd_pkg::PH_MARK);
      cnt_next = expire ? '0 : cnt_inc[TW-1:0];
      if (expire && phase == irpd_pkg::PH_IDLE) sending_next = 1'b0;
      if (go_space) phase_next = irpd_pkg::PH_SPACE;
    end
    if (go_mark) begin
      if (mark_len != '0) begin
        phase_next = irpd_pkg::PH_MARK;
        idx_next   = mark_j;
      end else if (found) begin
        phase_next = irpd_pkg::PH_SPACE;
        idx_next   = found_k;
      end
    end
    // End of frame: stop after the last repeat, else open the next frame with a fresh word.
    if (go_end || (go_mark && mark_len == '0 && !found)) begin
      rep_next = rep_inc;
      idx_next = '0;
      cnt_next = '0;
      if (rep_inc >= RW'(REPEATS)) begin
        sending_next = 1'b0;
        phase_next   = irpd_pkg::PH_IDLE;
      end else begin
        word_next  = irpd_pkg::next_frame_word(sel_word);
        phase_next = irpd_pkg::PH_GAP;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel  <= 3'd1;
      mark_len <= 8'd12;
      zero_len <= 8'd20;
      one_len  <= 8'd42;
      ss_len   <= 8'd78;
    end else if (cfg_we) begin
      case (cfg_index)
        irpd_pkg::CFG_CHANNEL:         channel  <= cfg_data[irpd_pkg::CH_W-1:0];
        irpd_pkg::CFG_MARK:            mark_len <= cfg_data[TW-1:0];
        irpd_pkg::CFG_ZERO_SPACE:      zero_len <= cfg_data[TW-1:0];
        irpd_pkg::CFG_ONE_SPACE:       one_len  <= cfg_data[TW-1:0];
        irpd_pkg::CFG_STARTSTOP_SPACE: ss_len   <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state: advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      word    <= '0;
      rep     <= '0;
      idx     <= '0;
      phase   <= irpd_pkg::PH_IDLE;
      cnt     <= '0;
      sending <= 1'b0;
    end else if (accept) begin
      word    <= word_next;
      rep     <= rep_next;
      idx     <= idx_next;
      phase   <= phase_next;
      cnt     <= cnt_next;
      sending <= sending_next;
    end
  end

  // Result register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_drive <= drive;
      res_busy  <= sending_next;
      res_word  <= word_next;
    end
  end

`ifndef SYNTHESIS
  // The sequencer sits in its idle phase exactly when no transmission runs.
  a_idle_iff_stopped: assert property (@(posedge clk) disable iff (rst)
    (phase == irpd_pkg::PH_IDLE) == !sending)
    else $error("phase and sending flag disagree");

  // Symbol index never passes the stop symbol.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= IW'(LAST))
    else $error("symbol index beyond stop symbol");

  // A running transmission is always on one of the configured repeats.
  a_rep_bound: assert property (@(posedge clk) disable iff (rst)
    sending |-> (rep < RW'(REPEATS)))
    else $error("repeat count out of range while sending");

  // A load item never yields carrier drive.
  a_load_no_drive: assert property (@(posedge clk) disable iff (rst)
    (accept && is_load) |=> !res_drive)
    else $error("load item produced carrier drive");
`endif

endmodule
